[rtl/lbq_pkg.sv]
// shared constants and types for the line to billboard quad unit
package lbq_pkg;

    // coordinate and field widths
    localparam int COORD_W   = 32;
    localparam int WIDTH_W   = 31;
    localparam int SE_W      = 6 * COORD_W;
    localparam int TCAM_W    = COORD_W + 2;

    // unit vectors are signed Q2.30
    localparam int UNIT_BITS = 30;
    localparam int UNIT_W    = UNIT_BITS + 2;
    localparam int NORM_BIT  = UNIT_BITS - 1;
    localparam int NM_W      = UNIT_BITS;
    localparam int SQ_W      = 2 * NM_W;
    localparam int MAG_W     = UNIT_BITS + 1;

    // square root and divider pipelines
    localparam int ISQ_STEPS = 32;
    localparam int ISQ_W     = 2 * ISQ_STEPS;
    localparam int LEN_W     = UNIT_BITS + 1;
    localparam int REM_W     = LEN_W;
    localparam int Q_W       = UNIT_BITS + 1;
    localparam int DIV_STEPS = UNIT_BITS + 1;

    // cross product
    localparam int PROD_W    = 2 * UNIT_W;
    localparam int CROSS_W   = 2 * UNIT_BITS + 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X,
        CFG_CAMERA_Y,
        CFG_CAMERA_Z
    } t_cfg_idx;

    // corners in emit order
    typedef enum logic [1:0] {
        CORNER_START_PLUS,
        CORNER_END_PLUS,
        CORNER_END_MINUS,
        CORNER_START_MINUS
    } t_corner;

    // pipeline control handed to a normalizer
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

[rtl/lbq_norm.sv]
// pipelined 3-vector normalizer: shift to range, sum of squares, square root, divide
module lbq_norm
    import lbq_pkg::*;
#(
    parameter int W      = TCAM_W,
    parameter int SIDE_W = WIDTH_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pipe_ctl                i_ctl,
    input  logic [2:0][W-1:0]        i_vec,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [2:0][UNIT_W-1:0]   o_unit,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int PW   = $clog2(W);
    localparam int NSTG = 6 + ISQ_STEPS + DIV_STEPS;

    logic [NSTG-1:0]        r_v;
    logic [SIDE_W-1:0]      r_side [NSTG];
    logic [2:0]             r_neg [NSTG-1];
    logic [NSTG-2:0]        r_zero;

    logic [2:0][W-1:0]      n_mag;
    logic [2:0][W-1:0]      r_mag0;
    logic [2:0][W-1:0]      r_mag1;
    logic [W-1:0]           r_or;
    logic [PW-1:0]          n_p;
    logic [PW-1:0]          r_p;
    logic [2:0][NM_W-1:0]   n_nm;
    logic [2:0][NM_W-1:0]   r_nm2;
    logic [2:0][NM_W-1:0]   r_nm3;
    logic [2:0][SQ_W-1:0]   r_sq;

    logic [ISQ_W-1:0]       r_qx [ISQ_STEPS];
    logic [ISQ_W-1:0]       r_qr [ISQ_STEPS];
    logic [2:0][NM_W-1:0]   r_qnm [ISQ_STEPS+1];
    logic [LEN_W-1:0]       r_len;

    logic [2:0][REM_W-1:0]  r_drem [DIV_STEPS-1];
    logic [LEN_W-1:0]       r_dlen [DIV_STEPS-1];
    logic [2:0][Q_W-1:0]    r_dq [DIV_STEPS];
    logic [2:0][UNIT_W-1:0] r_unit;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[NSTG-2:0], i_ctl.valid};
        end
    end

    // sideband, signs and zero flag delay lines
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_side[0] <= i_side;
            r_neg[0]  <= {i_vec[2][W-1], i_vec[1][W-1], i_vec[0][W-1]};
            r_zero    <= {r_zero[NSTG-3:0], (i_vec == '0)};
            for (int k = 1; k < NSTG; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 1; k < NSTG - 1; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][W-1] ? (~i_vec[i] + W'(1)) : i_vec[i];
        end
    end

    // leading one of the or of all magnitudes
    always_comb begin
        n_p = '0;
        for (int b = 0; b < W; b++) begin
            if (r_or[b]) begin
                n_p = PW'(b);
            end
        end
    end

    // shift so the largest magnitude lands in [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_p >= PW'(NORM_BIT)) begin
                n_nm[i] = NM_W'(r_mag1[i] >> (r_p - PW'(NORM_BIT)));
            end else begin
                n_nm[i] = NM_W'(r_mag1[i] << (PW'(NORM_BIT) - r_p));
            end
        end
    end

    // front stages: abs, leading one, shift, squares, sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_mag0   <= n_mag;
            r_or     <= n_mag[0] | n_mag[1] | n_mag[2];
            r_p      <= n_p;
            r_mag1   <= r_mag0;
            r_nm2    <= n_nm;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_nm2[i] * r_nm2[i];
            end
            r_nm3    <= r_nm2;
            r_qx[0]  <= ISQ_W'(r_sq[0]) + ISQ_W'(r_sq[1]) + ISQ_W'(r_sq[2]);
            r_qr[0]  <= '0;
            r_qnm[0] <= r_nm3;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic [ISQ_W-1:0] trial;
        logic             take;

        always_comb begin
            trial = r_qr[k] + BIT;
            take  = (r_qx[k] >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_qnm[k+1] <= r_qnm[k];
            end
        end

        if (k < ISQ_STEPS - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_qx[k+1] <= take ? (r_qx[k] - trial) : r_qx[k];
                    r_qr[k+1] <= take ? ((r_qr[k] >> 1) + BIT) : (r_qr[k] >> 1);
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_len <= take ? LEN_W'((r_qr[k] >> 1) + BIT) : LEN_W'(r_qr[k] >> 1);
                end
            end
        end
    end

    // restoring divide (nm << 30) / len, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [2:0][REM_W-1:0] rem_in;
        logic [2:0][Q_W-1:0]   q_in;
        logic [LEN_W-1:0]      len_in;
        logic [2:0]            bit_in;
        logic [2:0][REM_W:0]   trial;
        logic [2:0]            take;

        if (k == 0) begin : g_first
            always_comb begin
                len_in = r_len;
                q_in   = '0;
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = REM_W'(r_qnm[ISQ_STEPS][i] >> 1);
                    bit_in[i] = r_qnm[ISQ_STEPS][i][0];
                end
            end
        end else begin : g_next
            always_comb begin
                len_in = r_dlen[k-1];
                rem_in = r_drem[k-1];
                q_in   = r_dq[k-1];
                bit_in = '0;
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                trial[i] = {rem_in[i], bit_in[i]};
                take[i]  = (trial[i] >= {1'b0, len_in});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dq[k][i] <= {q_in[i][Q_W-2:0], take[i]};
                end
            end
        end

        if (k < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_dlen[k] <= len_in;
                    for (int i = 0; i < 3; i++) begin
                        r_drem[k][i] <= take[i] ? REM_W'(trial[i] - {1'b0, len_in})
                                                : trial[i][REM_W-1:0];
                    end
                end
            end
        end
    end

    // restore signs, zero vector gives zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_zero[NSTG-2]) begin
                    r_unit[i] <= '0;
                end else if (r_neg[NSTG-2][i]) begin
                    r_unit[i] <= UNIT_W'(0) - UNIT_W'(r_dq[DIV_STEPS-1][i]);
                end else begin
                    r_unit[i] <= UNIT_W'(r_dq[DIV_STEPS-1][i]);
                end
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_unit  = r_unit;
    assign o_side  = r_side[NSTG-1];

endmodule

[rtl/line_to_billboard_quad_unit.sv]
// top level: expands a 3-d line segment into four camera-facing quad corners
//
// Each accepted segment yields four corner words, start+n, end+n, end-n, start-n,
// with texture coordinates (0,0), (1,0), (1,1), (0,1); a segment whose start equals
// its end yields no words. The pipeline takes one segment per cycle, but the
// result channel carries one corner per cycle, so sustained throughput is set by
// the corner output stage: while a quad sits in the hold stage the whole pipeline
// and the input stall until its last corner leaves. From input accept to the first
// corner a segment passes one input stage, two normalizer passes of 69 stages each
// in series (direction and to-camera vectors side by side, then the cross product;
// a 32-stage square root and a 31-stage divider inside each), two cross product
// stages, three offset stages, the corner hold stage and the output register. The
// camera registers are written through the configuration port, which is always
// ready; write them only while no segment is in flight. Corners saturate to 32
// bits.
module line_to_billboard_quad_unit
    import lbq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [COORD_W-1:0]         i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [COORD_W-1:0]  i_start_x,
    input  logic signed [COORD_W-1:0]  i_start_y,
    input  logic signed [COORD_W-1:0]  i_start_z,
    input  logic signed [COORD_W-1:0]  i_end_x,
    input  logic signed [COORD_W-1:0]  i_end_y,
    input  logic signed [COORD_W-1:0]  i_end_z,
    input  logic [WIDTH_W-1:0]         i_line_width,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [COORD_W-1:0]  o_pos_x,
    output logic signed [COORD_W-1:0]  o_pos_y,
    output logic signed [COORD_W-1:0]  o_pos_z,
    output logic                       o_tex_u,
    output logic                       o_tex_v,
    output logic [1:0]                 o_corner,
    output logic                       o_last
);

    localparam int SIDE_B = SE_W + WIDTH_W;

    logic signed [COORD_W-1:0]   r_cam_x;
    logic signed [COORD_W-1:0]   r_cam_y;
    logic signed [COORD_W-1:0]   r_cam_z;

    logic signed [COORD_W-1:0]   s_in [3];
    logic signed [COORD_W-1:0]   e_in [3];
    logic signed [COORD_W-1:0]   cam [3];
    logic [2:0][TCAM_W-1:0]      n_d;
    logic [2:0][TCAM_W-1:0]      n_t;
    logic                        seg_zero;

    logic                        adv;
    logic                        out_load;
    logic                        hold_done;

    logic                        r_t0_v;
    logic [2:0][TCAM_W-1:0]      r_d;
    logic [2:0][TCAM_W-1:0]      r_t;
    logic [2:0][COORD_W-1:0]     r_s;
    logic [2:0][COORD_W-1:0]     r_e;
    logic [WIDTH_W-1:0]          r_w;

    t_pipe_ctl                   ctl_a;
    t_pipe_ctl                   ctl_b;
    logic                        dir_v;
    logic [2:0][UNIT_W-1:0]      dir_u;
    logic [SE_W-1:0]             dir_side;
    logic                        cam_v;
    logic [2:0][UNIT_W-1:0]      cam_u;
    logic [WIDTH_W-1:0]          cam_w;

    logic signed [UNIT_W-1:0]    du [3];
    logic signed [UNIT_W-1:0]    tu [3];
    logic                        r_c1_v;
    logic signed [PROD_W-1:0]    r_pr [6];
    logic [SIDE_B-1:0]           r_c1_side;
    logic                        r_c2_v;
    logic [2:0][CROSS_W-1:0]     r_c;
    logic [SIDE_B-1:0]           r_c2_side;

    logic                        nrm_v;
    logic [2:0][UNIT_W-1:0]      nrm_u;
    logic [SIDE_B-1:0]           nrm_side;

    logic                        r_s1_v;
    logic [2:0]                  r_s1_neg;
    logic [2:0][MAG_W-1:0]       r_s1_mag;
    logic [SIDE_B-1:0]           r_s1_side;
    logic                        r_s2_v;
    logic [2:0]                  r_s2_neg;
    logic [2:0][MAG_W+WIDTH_W-1:0] r_s2_prod;
    logic [SE_W-1:0]             r_s2_se;
    logic                        r_s3_v;
    logic [2:0][COORD_W-1:0]     r_s3_off;
    logic [SE_W-1:0]             r_s3_se;

    logic                        r_hold_v;
    t_corner                     r_cnt;
    logic [2:0][COORD_W-1:0]     r_hs;
    logic [2:0][COORD_W-1:0]     r_he;
    logic [2:0][COORD_W-1:0]     r_hoff;

    logic                        r_out_v;
    logic [2:0][COORD_W-1:0]     r_pos;
    logic                        r_tex_u;
    logic                        r_tex_v;
    logic [1:0]                  r_corner;
    logic                        r_last;
    logic [2:0][COORD_W-1:0]     n_pos;
    logic                        n_tex_u;
    logic                        n_tex_v;
    logic                        n_last;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
        if (v[COORD_W] != v[COORD_W-1]) begin
            return v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return v[COORD_W-1:0];
    endfunction

    // camera registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAMERA_X: r_cam_x <= i_cfg_data;
                CFG_CAMERA_Y: r_cam_y <= i_cfg_data;
                CFG_CAMERA_Z: r_cam_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline advances whenever the corner hold stage can take a new quad
    assign out_load  = r_hold_v && (!r_out_v || i_out_ready);
    assign hold_done = out_load && (r_cnt == CORNER_START_MINUS);
    assign adv       = !r_hold_v || hold_done;
    assign o_in_ready = adv;

    // direction and doubled to-camera vector
    always_comb begin
        s_in[0] = i_start_x;
        s_in[1] = i_start_y;
        s_in[2] = i_start_z;
        e_in[0] = i_end_x;
        e_in[1] = i_end_y;
        e_in[2] = i_end_z;
        cam[0]  = r_cam_x;
        cam[1]  = r_cam_y;
        cam[2]  = r_cam_z;
        for (int i = 0; i < 3; i++) begin
            n_d[i] = TCAM_W'(e_in[i]) - TCAM_W'(s_in[i]);
            n_t[i] = (TCAM_W'(cam[i]) <<< 1) - TCAM_W'(s_in[i]) - TCAM_W'(e_in[i]);
        end
        seg_zero = (i_start_x == i_end_x) && (i_start_y == i_end_y) &&
                   (i_start_z == i_end_z);
    end

    assign ctl_a = '{en: adv, valid: r_t0_v};
    assign ctl_b = '{en: adv, valid: r_c2_v};

    lbq_norm #(
        .W      (TCAM_W),
        .SIDE_W (SE_W)
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_vec   (r_d),
        .i_side  ({r_e, r_s}),
        .o_valid (dir_v),
        .o_unit  (dir_u),
        .o_side  (dir_side)
    );

    lbq_norm #(
        .W      (TCAM_W),
        .SIDE_W (WIDTH_W)
    ) u_norm_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_vec   (r_t),
        .i_side  (r_w),
        .o_valid (cam_v),
        .o_unit  (cam_u),
        .o_side  (cam_w)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            du[i] = $signed(dir_u[i]);
            tu[i] = $signed(cam_u[i]);
        end
    end

    lbq_norm #(
        .W      (CROSS_W),
        .SIDE_W (SIDE_B)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .i_vec   (r_c),
        .i_side  (r_c2_side),
        .o_valid (nrm_v),
        .o_unit  (nrm_u),
        .o_side  (nrm_side)
    );

    // corner for the current count
    always_comb begin
        logic [2:0][COORD_W-1:0] base;
        logic                    plus;
        logic signed [COORD_W:0] sum;
        base    = r_hs;
        plus    = 1'b1;
        n_tex_u = 1'b0;
        n_tex_v = 1'b0;
        n_last  = 1'b0;
        case (r_cnt)
            CORNER_START_PLUS: begin
                base = r_hs;
                plus = 1'b1;
            end
            CORNER_END_PLUS: begin
                base    = r_he;
                plus    = 1'b1;
                n_tex_u = 1'b1;
            end
            CORNER_END_MINUS: begin
                base    = r_he;
                plus    = 1'b0;
                n_tex_u = 1'b1;
                n_tex_v = 1'b1;
            end
            CORNER_START_MINUS: begin
                base    = r_hs;
                plus    = 1'b0;
                n_tex_v = 1'b1;
                n_last  = 1'b1;
            end
            default: begin
                base = r_hs;
                plus = 1'b1;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            if (plus) begin
                sum = (COORD_W+1)'($signed(base[i])) + (COORD_W+1)'($signed(r_hoff[i]));
            end else begin
                sum = (COORD_W+1)'($signed(base[i])) - (COORD_W+1)'($signed(r_hoff[i]));
            end
            n_pos[i] = sat_coord(sum);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v   <= 1'b0;
            r_c1_v   <= 1'b0;
            r_c2_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_hold_v <= 1'b0;
            r_cnt    <= CORNER_START_PLUS;
            r_out_v  <= 1'b0;
        end else begin
            if (adv) begin
                r_t0_v   <= i_in_valid && !seg_zero;
                r_c1_v   <= dir_v && cam_v;
                r_c2_v   <= r_c1_v;
                r_s1_v   <= nrm_v;
                r_s2_v   <= r_s1_v;
                r_s3_v   <= r_s2_v;
                r_hold_v <= r_s3_v;
                r_cnt    <= CORNER_START_PLUS;
            end else if (out_load) begin
                r_cnt <= t_corner'(r_cnt + 2'd1);
            end
            if (!r_out_v || i_out_ready) begin
                r_out_v <= r_hold_v;
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d <= n_d;
            r_t <= n_t;
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= s_in[i];
                r_e[i] <= e_in[i];
            end
            r_w <= i_line_width;

            // cross product terms
            r_pr[0]   <= du[1] * tu[2];
            r_pr[1]   <= du[2] * tu[1];
            r_pr[2]   <= du[2] * tu[0];
            r_pr[3]   <= du[0] * tu[2];
            r_pr[4]   <= du[0] * tu[1];
            r_pr[5]   <= du[1] * tu[0];
            r_c1_side <= {cam_w, dir_side};

            r_c[0]    <= CROSS_W'(r_pr[0] - r_pr[1]);
            r_c[1]    <= CROSS_W'(r_pr[2] - r_pr[3]);
            r_c[2]    <= CROSS_W'(r_pr[4] - r_pr[5]);
            r_c2_side <= r_c1_side;

            // offset = n * width / 2^31, truncated toward zero
            for (int i = 0; i < 3; i++) begin
                r_s1_neg[i] <= nrm_u[i][UNIT_W-1];
                r_s1_mag[i] <= nrm_u[i][UNIT_W-1] ? MAG_W'(~nrm_u[i] + UNIT_W'(1))
                                                  : MAG_W'(nrm_u[i]);
                r_s2_prod[i] <= r_s1_mag[i] * r_s1_side[SIDE_B-1:SE_W];
                r_s3_off[i]  <= r_s2_neg[i]
                    ? COORD_W'(0) - COORD_W'(r_s2_prod[i] >> (UNIT_BITS + 1))
                    : COORD_W'(r_s2_prod[i] >> (UNIT_BITS + 1));
            end
            r_s1_side <= nrm_side;
            r_s2_neg  <= r_s1_neg;
            r_s2_se   <= r_s1_side[SE_W-1:0];
            r_s3_se   <= r_s2_se;

            r_hs   <= r_s3_se[SE_W/2-1:0];
            r_he   <= r_s3_se[SE_W-1:SE_W/2];
            r_hoff <= r_s3_off;
        end
        if (out_load) begin
            r_pos    <= n_pos;
            r_tex_u  <= n_tex_u;
            r_tex_v  <= n_tex_v;
            r_corner <= r_cnt;
            r_last   <= n_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];
    assign o_tex_u     = r_tex_u;
    assign o_tex_v     = r_tex_v;
    assign o_corner    = r_corner;
    assign o_last      = r_last;

    // a quad stays in the hold stage until its fourth corner leaves
    a_hold_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v && !hold_done |=> r_hold_v)
        else $error("hold stage dropped a quad before its last corner");

    // input stalls only while a quad is being emitted
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_hold_v)
        else $error("input stalled with an empty hold stage");

    // corners of one quad follow back to back in order
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=>
            o_out_valid && (o_corner == $past(o_corner) + 2'd1))
        else $error("corner sequence broken");

endmodule

[sim/line_to_billboard_quad_unit_test.sv]
// testbench for the line to billboard quad unit: random and directed segments checked against a predictor
module line_to_billboard_quad_unit_test
    import lbq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY_WAIT  = 200;
    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  ITEMS_PER_PHASE = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
        logic [WIDTH_W-1:0]        w;
    } seg_t;

    typedef struct {
        logic signed [COORD_W-1:0] px, py, pz;
        logic                      u, v;
        t_corner                   idx;
        logic                      last;
    } corner_t;

    typedef longint vec3_t [3];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [COORD_W-1:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [COORD_W-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic [WIDTH_W-1:0] i_line_width = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid;
    logic signed [COORD_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic o_tex_u, o_tex_v, o_last;
    logic [1:0] o_corner;

    line_to_billboard_quad_unit DUT (.*);

    // stimulus and expectation stores
    seg_t    seg_q[$];
    corner_t corner_q[$];
    seg_t    cur_seg;
    longint  camera[3] = '{0, 0, 0};
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_req = 0;
    int      hold_left = 0;
    logic    hold_on = 1'b0;
    int      errors = 0;
    int      cycles = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // floor integer square root
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // signed Q2.30 unit vector, zero for a zero input
    function automatic void unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned mag[3];
        bit neg[3];
        longint unsigned m, sum, len;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        u = '{0, 0, 0};
        if (m == 0) return;
        while (m >= (64'd1 << UNIT_BITS)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << NORM_BIT)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'((mag[i] << UNIT_BITS) / len);
            if (neg[i]) u[i] = -u[i];
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp32(longint v);
        if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    // expected corners of one segment
    function automatic void predict_quad(seg_t s);
        vec3_t st, en, d, t, du, tu, c, n, off;
        longint unsigned mag;
        corner_t q;
        st = '{longint'(s.sx), longint'(s.sy), longint'(s.sz)};
        en = '{longint'(s.ex), longint'(s.ey), longint'(s.ez)};
        for (int i = 0; i < 3; i++) begin
            d[i] = en[i] - st[i];
            t[i] = 2 * camera[i] - (st[i] + en[i]);
        end
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) return;
        unit_vec(d, du);
        unit_vec(t, tu);
        c[0] = du[1] * tu[2] - du[2] * tu[1];
        c[1] = du[2] * tu[0] - du[0] * tu[2];
        c[2] = du[0] * tu[1] - du[1] * tu[0];
        unit_vec(c, n);
        for (int i = 0; i < 3; i++) begin
            mag = n[i] < 0 ? -n[i] : n[i];
            off[i] = longint'((mag * longint'(s.w)) >> (UNIT_BITS + 1));
            if (n[i] < 0) off[i] = -off[i];
        end
        for (int k = 0; k < 4; k++) begin
            vec3_t b;
            if (k == 0 || k == 3) begin
                b = st;
            end else begin
                b = en;
            end
            if (k < 2) begin
                q.px = clamp32(b[0] + off[0]);
                q.py = clamp32(b[1] + off[1]);
                q.pz = clamp32(b[2] + off[2]);
            end else begin
                q.px = clamp32(b[0] - off[0]);
                q.py = clamp32(b[1] - off[1]);
                q.pz = clamp32(b[2] - off[2]);
            end
            q.u = (k == 1 || k == 2);
            q.v = (k >= 2);
            q.idx = t_corner'(k);
            q.last = (k == 3);
            corner_q.push_back(q);
        end
    endfunction

    // segment driver
    always @(posedge i_clk) begin
        bit fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) predict_quad(cur_seg);
            if (!i_in_valid || fire) begin
                if (seg_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_seg = seg_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_start_x    <= cur_seg.sx;
                    i_start_y    <= cur_seg.sy;
                    i_start_z    <= cur_seg.sz;
                    i_end_x      <= cur_seg.ex;
                    i_end_y      <= cur_seg.ey;
                    i_end_z      <= cur_seg.ez;
                    i_line_width <= cur_seg.w;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) hold_left--;
        hold_on <= (hold_left > 0);
    end

    // corner monitor with random stalls
    always @(posedge i_clk) begin
        corner_t e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (corner_q.size() == 0) begin
                    $error("corner word with no expectation waiting");
                    errors++;
                end else begin
                    e = corner_q.pop_front();
                    if (o_pos_x !== e.px) begin
                        $error("pos_x expected %0d got %0d", e.px, o_pos_x); errors++;
                    end
                    if (o_pos_y !== e.py) begin
                        $error("pos_y expected %0d got %0d", e.py, o_pos_y); errors++;
                    end
                    if (o_pos_z !== e.pz) begin
                        $error("pos_z expected %0d got %0d", e.pz, o_pos_z); errors++;
                    end
                    if (o_tex_u !== e.u) begin
                        $error("tex_u expected %0d got %0d", e.u, o_tex_u); errors++;
                    end
                    if (o_tex_v !== e.v) begin
                        $error("tex_v expected %0d got %0d", e.v, o_tex_v); errors++;
                    end
                    if (o_corner !== e.idx) begin
                        $error("corner expected %0d got %0d", e.idx, o_corner); errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last expected %0d got %0d", e.last, o_last); errors++;
                    end
                end
            end
            if (hold_on) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic seg_t make_seg(longint sx, longint sy, longint sz,
                                      longint ex, longint ey, longint ez, longint w);
        seg_t s;
        s.sx = sx[31:0]; s.sy = sy[31:0]; s.sz = sz[31:0];
        s.ex = ex[31:0]; s.ey = ey[31:0]; s.ez = ez[31:0];
        s.w = w[30:0];
        return s;
    endfunction

    // random segment: mostly moderate coordinates, some full range, a few degenerate
    function automatic seg_t rand_seg();
        seg_t s;
        int mode;
        mode = $urandom_range(9);
        s.w = (mode < 2) ? WIDTH_W'($urandom()) : WIDTH_W'($urandom_range(32'h0040_0000));
        if (mode < 3) begin
            s.sx = $urandom(); s.sy = $urandom(); s.sz = $urandom();
            s.ex = $urandom(); s.ey = $urandom(); s.ez = $urandom();
        end else begin
            s.sx = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            s.sy = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            s.sz = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            s.ex = s.sx + $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
            s.ey = s.sy + $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
            s.ez = s.sz + $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
        end
        if (mode == 9) begin
            s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
        end
        return s;
    endfunction

    // wait until nothing is in flight, then let the pipeline drain
    task automatic wait_idle();
        while (seg_q.size() != 0 || i_in_valid || corner_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    // one register write; leaves valid high for a following write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CAMERA_X) camera[0] = longint'($signed(data));
        else if (idx == CFG_CAMERA_Y) camera[1] = longint'($signed(data));
        else if (idx == CFG_CAMERA_Z) camera[2] = longint'($signed(data));
    endtask

    task automatic set_camera(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z);
        wait_idle();
        cfg_write(CFG_CAMERA_X, x);
        cfg_write(CFG_CAMERA_Y, y);
        cfg_write(CFG_CAMERA_Z, z);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    localparam longint ONE = 64'sd65536;

    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 72, 0, 24};
        stall_set = '{0, 0, 72, 24};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed segments at the reset camera position
        seg_q.push_back(make_seg(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, ONE));
        seg_q.push_back(make_seg(-ONE, -ONE, 0, ONE, ONE, 0, 2 * ONE));
        seg_q.push_back(make_seg(ONE, 0, 0, 3 * ONE, 0, 0, 2 * ONE));
        seg_q.push_back(make_seg(ONE, ONE, 5 * ONE, 3 * ONE, ONE, 5 * ONE, 0));
        seg_q.push_back(make_seg(ONE, ONE, 5 * ONE, 3 * ONE, ONE, 5 * ONE, 32'h7FFF_FFFF));
        seg_q.push_back(make_seg(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                 -64'sh8000_0000, 32'sh7FFF_0000, -64'sh8000_0000,
                                 32'h7FFF_FFFF));
        seg_q.push_back(make_seg(-64'sh8000_0000, -64'sh8000_0000, 0,
                                 -64'sh8000_0000, 32'sh7FFF_FFFF, ONE, 32'h7FFF_FFFF));
        seg_q.push_back(make_seg(0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF));
        seg_q.push_back(make_seg(32'sh7FFF_FFFF, 0, ONE, 32'sh7FFF_FFFF, 1, ONE, ONE));
        seg_q.push_back(make_seg(32'sh5555_5555, -64'sh2AAA_AAAB, 32'sh1234_5678,
                                 -64'sh5555_5556, 32'sh2AAA_AAAA, -64'sh1234_5679,
                                 32'h5555_5555));
        wait_idle();

        // unused register index, then cameras at the extremes
        cfg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) seg_q.push_back(rand_seg());
        seg_q.push_back(make_seg(-ONE, 0, 0, ONE, 0, 0, 3 * ONE));
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++) seg_q.push_back(rand_seg());
        // camera exactly at the midpoint
        set_camera(ONE, ONE, ONE);
        seg_q.push_back(make_seg(0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, ONE));

        // random phases with different idling patterns
        for (int p = 0; p < 4; p++) begin
            set_camera($urandom(), $urandom(), $urandom());
            if (p == 1) set_camera($urandom_range(32'h00FF_FFFF), 32'h0010_0000, 0);
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            if (p == 0) hold_req = 600;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) seg_q.push_back(rand_seg());
        end

        wait_idle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lbq_pkg.sv
rtl/lbq_norm.sv
rtl/line_to_billboard_quad_unit.sv
sim/line_to_billboard_quad_unit_test.sv
